FILE: hw/rtl/spe_pkg.sv
// Shared types, constants and arithmetic helpers of the stereo peaking equaliser.
package spe_pkg;

	localparam int BANDS_DEF = 12;
	localparam int NCOEF     = 5;
	localparam int CW        = 32;
	localparam int CFB       = 28;
	localparam int SW        = 24;
	localparam int OW        = 21;
	localparam int DW        = 40;
	localparam int ZLW       = 20;
	localparam int PW        = 44;
	localparam int AW        = 46;
	localparam int BSW       = 4;
	localparam int CSW       = 3;
	localparam int OUT_SH    = 8;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_WRITE  = 1'b1;

	localparam logic signed [CW-1:0] Q_ONE = 32'sh1000_0000;

	localparam logic signed [AW-1:0] ACC_HI = {{(AW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [AW-1:0] ACC_LO = {{(AW-DW+1){1'b1}}, {(DW-1){1'b0}}};

	localparam logic signed [DW-OUT_SH:0] OUT_HI = (DW-OUT_SH+1)'(655360);
	localparam logic signed [DW-OUT_SH:0] OUT_LO = -OUT_HI;

	typedef enum logic [CSW-1:0] {
		C_B0,
		C_B1,
		C_B2,
		C_A1,
		C_A2
	} coef_sel_t;

	typedef enum logic [1:0] {
		OP_Z1,
		OP_Z2,
		OP_W
	} opnd_sel_t;

	typedef enum logic [2:0] {
		ACC_NONE,
		ACC_W_FIRST,
		ACC_W_FINAL,
		ACC_Y_FIRST,
		ACC_Y_ADD,
		ACC_Y_FINAL
	} acc_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} seq_state_t;

	typedef enum logic [2:0] {
		SP_LOAD,
		SP_A1,
		SP_A2,
		SP_B1,
		SP_B2,
		SP_B0,
		SP_Y_ADD,
		SP_Y_END
	} step_t;

	typedef logic [NCOEF-1:0][CW-1:0] coef_row_t;

	localparam coef_row_t COEF_ROW_RST = {{((NCOEF-1)*CW){1'b0}}, Q_ONE};

	typedef struct packed {
		logic      start;
		logic      load;
		coef_sel_t coef;
		opnd_sel_t opnd;
		acc_op_t   acc;
	} lane_ctl_t;

	function automatic int band_w(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	// saturate an accumulator to the 40-bit delay word range
	function automatic logic signed [DW-1:0] sat_dw(input logic signed [AW-1:0] v);
		if (v > ACC_HI)
			return ACC_HI[DW-1:0];
		else if (v < ACC_LO)
			return ACC_LO[DW-1:0];
		else
			return v[DW-1:0];
	endfunction

	// Q16.24 to Q5.16, round half up, clamp to +-10 V
	function automatic logic signed [OW-1:0] round_out(input logic signed [DW-1:0] x);
		logic signed [DW:0]        r;
		logic signed [DW-OUT_SH:0] s;
		r = $signed({x[DW-1], x}) + (DW+1)'(1 << (OUT_SH-1));
		s = r[DW:OUT_SH];
		if (s > OUT_HI)
			return OUT_HI[OW-1:0];
		else if (s < OUT_LO)
			return OUT_LO[OW-1:0];
		else
			return s[OW-1:0];
	endfunction

endpackage

FILE: hw/rtl/spe_in_if.sv
// Input channel: sample or coefficient-write word with valid/ready.
interface spe_in_if;
	import spe_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  cmd;
	logic signed [SW-1:0]  left_in;
	logic signed [SW-1:0]  right_in;
	logic [BSW-1:0]        band_sel;
	logic [CSW-1:0]        coef_sel;
	logic signed [CW-1:0]  coef_value;

	modport source (
		output valid, cmd, left_in, right_in, band_sel, coef_sel, coef_value,
		input  ready
	);

	modport sink (
		input  valid, cmd, left_in, right_in, band_sel, coef_sel, coef_value,
		output ready
	);
endinterface

FILE: hw/rtl/spe_out_if.sv
// Output channel: filtered stereo word with valid/ready.
interface spe_out_if;
	import spe_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [OW-1:0]  left_out;
	logic signed [OW-1:0]  right_out;

	modport source (
		output valid, left_out, right_out,
		input  ready
	);

	modport sink (
		input  valid, left_out, right_out,
		output ready
	);
endinterface

FILE: hw/rtl/spe_coef_store.sv
// Shared coefficient store, one row of five coefficients per band, registered row read.
module spe_coef_store #(
	parameter int BANDS = spe_pkg::BANDS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  wr_en,
	input  logic [spe_pkg::BSW-1:0]               wr_band,
	input  logic [spe_pkg::CSW-1:0]               wr_sel,
	input  logic [spe_pkg::CW-1:0]                wr_data,
	input  logic                                  rd_en,
	input  logic [spe_pkg::band_w(BANDS)-1:0]     rd_band,
	output spe_pkg::coef_row_t                    row
);
	import spe_pkg::*;

	localparam int BW = band_w(BANDS);

	coef_row_t rows_q [BANDS];
	coef_row_t row_q;
	logic      wr_ok;

	assign wr_ok = wr_en && ({1'b0, wr_band} < (BSW+1)'(BANDS)) && (wr_sel <= CSW'(C_A2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANDS; i++)
				rows_q[i] <= COEF_ROW_RST;
		end else if (wr_ok) begin
			rows_q[wr_band[BW-1:0]][wr_sel] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			row_q <= rows_q[rd_band];
	end

	assign row = row_q;

endmodule

FILE: hw/rtl/spe_lane.sv
// One channel lane: delay words, split 32x40 multiplier pipeline and biquad accumulator.
module spe_lane #(
	parameter int BANDS = spe_pkg::BANDS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  spe_pkg::lane_ctl_t                    ctl,
	input  logic [spe_pkg::band_w(BANDS)-1:0]     band,
	input  logic signed [spe_pkg::SW-1:0]         sample,
	input  spe_pkg::coef_row_t                    row,
	output logic signed [spe_pkg::DW-1:0]         y
);
	import spe_pkg::*;

	localparam int FW = CW + DW + 1;
	localparam logic signed [FW-1:0] PRND = FW'(1) <<< (CFB-1);

	logic signed [DW-1:0]      z1_mem_q [BANDS];
	logic signed [DW-1:0]      z2_mem_q [BANDS];
	logic signed [DW-1:0]      z1_q, z2_q, w_q, x_q;
	logic signed [AW-1:0]      acc_q;
	logic signed [CW-1:0]      c_sel;
	logic signed [DW-1:0]      z_sel;
	logic signed [DW-ZLW-1:0]  zh;
	logic [ZLW-1:0]            zl;
	logic signed [CW+ZLW-1:0]  pa_s1;
	logic signed [CW+ZLW:0]    pb_s1;
	logic signed [FW-1:0]      full;
	logic signed [PW-1:0]      prod_s2;

	always_comb begin
		unique case (ctl.coef)
			C_B0:    c_sel = $signed(row[C_B0]);
			C_B1:    c_sel = $signed(row[C_B1]);
			C_B2:    c_sel = $signed(row[C_B2]);
			C_A1:    c_sel = $signed(row[C_A1]);
			C_A2:    c_sel = $signed(row[C_A2]);
			default: c_sel = '0;
		endcase
		unique case (ctl.opnd)
			OP_Z1:   z_sel = z1_q;
			OP_Z2:   z_sel = z2_q;
			OP_W:    z_sel = w_q;
			default: z_sel = '0;
		endcase
	end

	assign zh = z_sel[DW-1:ZLW];
	assign zl = z_sel[ZLW-1:0];

	// exact product as two partials, recombined and rounded to Q20.24
	assign full = (FW'(pa_s1) <<< ZLW) + FW'(pb_s1) + PRND;

	always_ff @(posedge clk) begin
		pa_s1   <= c_sel * zh;
		pb_s1   <= c_sel * $signed({1'b0, zl});
		prod_s2 <= full[PW+CFB-1:CFB];
	end

	always_ff @(posedge clk) begin
		if (ctl.start)
			x_q <= {{(DW-SW-OUT_SH){sample[SW-1]}}, sample, {OUT_SH{1'b0}}};
		if (ctl.load) begin
			z1_q <= z1_mem_q[band];
			z2_q <= z2_mem_q[band];
		end
		unique case (ctl.acc)
			ACC_NONE:    ;
			ACC_W_FIRST: acc_q <= AW'(x_q) - AW'(prod_s2);
			ACC_W_FINAL: w_q   <= sat_dw(acc_q - AW'(prod_s2));
			ACC_Y_FIRST: acc_q <= AW'(prod_s2);
			ACC_Y_ADD:   acc_q <= acc_q + AW'(prod_s2);
			ACC_Y_FINAL: x_q   <= sat_dw(acc_q + AW'(prod_s2));
			default:     ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BANDS; i++) begin
				z1_mem_q[i] <= '0;
				z2_mem_q[i] <= '0;
			end
		end else if (ctl.acc == ACC_Y_FINAL) begin
			z1_mem_q[band] <= w_q;
			z2_mem_q[band] <= z1_q;
		end
	end

	assign y = x_q;

endmodule

FILE: hw/rtl/spe_merge.sv
// Merges the two lane results: rounding, clamping and the output register.
module spe_merge (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  logic signed [spe_pkg::DW-1:0] left_y,
	input  logic signed [spe_pkg::DW-1:0] right_y,
	output logic                          free,
	spe_out_if.source                     out
);
	import spe_pkg::*;

	logic                 valid_q;
	logic signed [OW-1:0] left_q, right_q;

	assign free = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (out.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_q  <= round_out(left_y);
			right_q <= round_out(right_y);
		end
	end

	assign out.valid     = valid_q;
	assign out.left_out  = left_q;
	assign out.right_out = right_q;

endmodule

FILE: hw/rtl/stereo_peaking_eq_cascade.sv
// Stereo cascade of BANDS peaking biquads (direct form II), left and right run in two lanes
// side by side that share one coefficient store. A coefficient-write word is taken only while
// the block is idle and gives no result. A sample word is taken only while the block is idle
// too; each lane has one two-stage 32x40 multiplier that steps through the five products of
// a band, band after band, and the hold state then hands the result to the output register,
// waiting while that register still holds an unread result. The next word is taken only
// after that hand-over, so a new sample waits until the last one is through. The output
// register holds a finished result while the next word is accepted.
module stereo_peaking_eq_cascade #(
	parameter int BANDS = spe_pkg::BANDS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	spe_in_if.sink    in,
	spe_out_if.source out
);
	import spe_pkg::*;

	localparam int BW = band_w(BANDS);

	seq_state_t           state_q, state_d;
	step_t                step_q, step_d;
	logic [BW-1:0]        band_q, band_d;
	lane_ctl_t            ctl;
	logic                 rdy, wr_en, fin, mrg_free;
	coef_row_t            row;
	logic signed [DW-1:0] left_y, right_y;

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		band_d  = band_q;
		ctl     = '0;
		rdy     = 1'b0;
		wr_en   = 1'b0;
		fin     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				rdy = 1'b1;
				if (in.valid) begin
					if (in.cmd == CMD_WRITE) begin
						wr_en = 1'b1;
					end else begin
						ctl.start = 1'b1;
						state_d   = ST_RUN;
					end
				end
			end
			ST_RUN: begin
				unique case (step_q)
					SP_LOAD:  ctl.load = 1'b1;
					SP_A1: begin
						ctl.coef = C_A1;
						ctl.opnd = OP_Z1;
					end
					SP_A2: begin
						ctl.coef = C_A2;
						ctl.opnd = OP_Z2;
					end
					SP_B1: begin
						ctl.coef = C_B1;
						ctl.opnd = OP_Z1;
						ctl.acc  = ACC_W_FIRST;
					end
					SP_B2: begin
						ctl.coef = C_B2;
						ctl.opnd = OP_Z2;
						ctl.acc  = ACC_W_FINAL;
					end
					SP_B0: begin
						ctl.coef = C_B0;
						ctl.opnd = OP_W;
						ctl.acc  = ACC_Y_FIRST;
					end
					SP_Y_ADD: ctl.acc = ACC_Y_ADD;
					SP_Y_END: ctl.acc = ACC_Y_FINAL;
					default:  ;
				endcase
				if (step_q == SP_Y_END) begin
					step_d = SP_LOAD;
					if (band_q == BW'(BANDS-1)) begin
						band_d  = '0;
						state_d = ST_HOLD;
					end else begin
						band_d = band_q + BW'(1);
					end
				end else begin
					step_d = step_t'(step_q + 3'd1);
				end
			end
			ST_HOLD: begin
				if (mrg_free) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= SP_LOAD;
			band_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			band_q  <= band_d;
		end
	end

	assign in.ready = rdy;

	spe_coef_store #(.BANDS(BANDS)) u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_band (in.band_sel),
		.wr_sel  (in.coef_sel),
		.wr_data (in.coef_value),
		.rd_en   (ctl.load),
		.rd_band (band_q),
		.row     (row)
	);

	spe_lane #(.BANDS(BANDS)) u_lane_l (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.band   (band_q),
		.sample (in.left_in),
		.row    (row),
		.y      (left_y)
	);

	spe_lane #(.BANDS(BANDS)) u_lane_r (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.band   (band_q),
		.sample (in.right_in),
		.row    (row),
		.y      (right_y)
	);

	spe_merge u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (fin),
		.left_y  (left_y),
		.right_y (right_y),
		.free    (mrg_free),
		.out     (out)
	);

	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> step_q == SP_LOAD && band_q == '0)
		else $error("sequencer counters not cleared in idle");

	a_band_rng: assert property (@(posedge clk) disable iff (!arst_n)
		band_q <= BW'(BANDS-1))
		else $error("band counter out of range");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in.valid && in.ready && in.cmd == CMD_SAMPLE) |=>
			state_q == ST_RUN && step_q == SP_LOAD && band_q == '0)
		else $error("sample word did not start the band sweep");

	a_out_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out.valid) |-> $past(state_q == ST_HOLD))
		else $error("result word raised outside the hand-over step");

endmodule

FILE: tb/sv/spe_eq_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the stereo equaliser: predicts each filtered word and checks the output channel.
module spe_eq_checker #(
	parameter int BANDS = spe_pkg::BANDS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	spe_in_if    in_ch,
	spe_out_if   out_ch,
	output int   fails,
	output int   pending
);
	import spe_pkg::*;

	localparam int PRODW  = CW + DW;
	localparam int TERMW  = PRODW - CFB;
	localparam int SUMW   = TERMW + 2;
	localparam int RND_SH = 8;

	localparam logic signed [SUMW-1:0] DLY_MAX = {{(SUMW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [SUMW-1:0] DLY_MIN = {{(SUMW-DW+1){1'b1}}, {(DW-1){1'b0}}};
	localparam logic signed [DW-RND_SH:0] CLAMP = 655360;

	typedef struct packed {
		logic signed [OW-1:0] left;
		logic signed [OW-1:0] right;
	} stereo_t;

	logic signed [CW-1:0] coef_mem [BANDS*NCOEF];
	logic signed [DW-1:0] dly_mem [2][BANDS*2];
	stereo_t              expected_q [$];
	int                   reported = 0;

	// exact coefficient x delay word product, rounded half up to Q20.24
	function automatic logic signed [TERMW-1:0] mul_q24(input logic signed [CW-1:0] c,
			input logic signed [DW-1:0] z);
		logic signed [PRODW-1:0] p;
		p = PRODW'(c) * PRODW'(z);
		p = p + (PRODW'(1) <<< (CFB - 1));
		return p[PRODW-1:CFB];
	endfunction

	function automatic logic signed [DW-1:0] clip_dw(input logic signed [SUMW-1:0] v);
		if (v > DLY_MAX)
			return DLY_MAX[DW-1:0];
		else if (v < DLY_MIN)
			return DLY_MIN[DW-1:0];
		else
			return v[DW-1:0];
	endfunction

	// one channel through every band, updating its delay words
	function automatic logic signed [OW-1:0] filter_chain(input int ch,
			input logic signed [SW-1:0] smp);
		logic signed [DW-1:0]       x;
		logic signed [DW-1:0]       z1;
		logic signed [DW-1:0]       z2;
		logic signed [DW-1:0]       w;
		logic signed [SUMW-1:0]     acc;
		logic signed [DW:0]         r;
		logic signed [DW-RND_SH:0] q;
		int                         base;
		x = {{(DW-SW-RND_SH){smp[SW-1]}}, smp, {RND_SH{1'b0}}};
		for (int b = 0; b < BANDS; b++) begin
			base = b * NCOEF;
			z1 = dly_mem[ch][2*b];
			z2 = dly_mem[ch][2*b+1];
			acc = SUMW'(x);
			acc = acc - SUMW'(mul_q24(coef_mem[base + C_A1], z1));
			acc = acc - SUMW'(mul_q24(coef_mem[base + C_A2], z2));
			w = clip_dw(acc);
			acc = SUMW'(mul_q24(coef_mem[base + C_B0], w));
			acc = acc + SUMW'(mul_q24(coef_mem[base + C_B1], z1));
			acc = acc + SUMW'(mul_q24(coef_mem[base + C_B2], z2));
			x = clip_dw(acc);
			dly_mem[ch][2*b+1] = z1;
			dly_mem[ch][2*b] = w;
		end
		r = x + (DW+1)'(1 << (RND_SH - 1));
		q = r[DW:RND_SH];
		if (q > CLAMP)
			q = CLAMP;
		else if (q < -CLAMP)
			q = -CLAMP;
		return q[OW-1:0];
	endfunction

	always @(posedge clk) begin
		stereo_t want;
		if (!arst_n) begin
			for (int i = 0; i < BANDS*NCOEF; i++)
				coef_mem[i] = (i % NCOEF == C_B0) ? Q_ONE : '0;
			for (int i = 0; i < BANDS*2; i++) begin
				dly_mem[0][i] = '0;
				dly_mem[1][i] = '0;
			end
			expected_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				if (in_ch.cmd == CMD_WRITE) begin
					if (in_ch.band_sel < BANDS && in_ch.coef_sel < NCOEF)
						coef_mem[in_ch.band_sel * NCOEF + in_ch.coef_sel] = in_ch.coef_value;
				end else begin
					want.left = filter_chain(0, in_ch.left_in);
					want.right = filter_chain(1, in_ch.right_in);
					expected_q.push_back(want);
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				if (expected_q.size() == 0) begin
					fails++;
					if (reported < 10) begin
						reported++;
						$display("unexpected word: left %0d right %0d",
							out_ch.left_out, out_ch.right_out);
					end
				end else begin
					want = expected_q.pop_front();
					if (out_ch.left_out !== want.left || out_ch.right_out !== want.right) begin
						fails++;
						if (reported < 10) begin
							reported++;
							$display("word mismatch: left exp %0d got %0d, right exp %0d got %0d",
								want.left, out_ch.left_out, want.right, out_ch.right_out);
						end
					end
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

FILE: tb/sv/stereo_peaking_eq_cascade_tb.sv
`timescale 1ns / 100ps
// Testbench top for the stereo equaliser: clock, reset, stimulus, back-pressure and verdict.
module stereo_peaking_eq_cascade_tb;
	import spe_pkg::*;

	localparam int BANDS       = BANDS_DEF;
	localparam int ITEMS       = 800;
	localparam int LIMIT       = 1000000;
	localparam int DRAIN       = 8*BANDS + 60;
	localparam int HOLD_CYCLES = 600;
	localparam int FULL_SCALE  = 655360;

	localparam logic [CSW-1:0] SEL_BAD_LO = 3'd5;
	localparam logic [CSW-1:0] SEL_BAD_HI = 3'd7;
	localparam logic [BSW-1:0] BAND_TOP   = 4'hF;

	localparam logic signed [CW-1:0] COEF_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] COEF_MIN = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [SW-1:0] SMP_MAX  = {1'b0, {(SW-1){1'b1}}};
	localparam logic signed [SW-1:0] SMP_MIN  = {1'b1, {(SW-1){1'b0}}};

	logic clk;
	logic arst_n;
	logic hold_req;
	int   fails;
	int   pending;
	int   cycle_cnt;
	int   tx_idle;
	int   rx_idle;
	int   counted;

	spe_in_if  in_ch();
	spe_out_if out_ch();

	stereo_peaking_eq_cascade #(.BANDS(BANDS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch),
		.out    (out_ch)
	);

	spe_eq_checker #(.BANDS(BANDS)) eq_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.fails   (fails),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	initial begin : receiver
		int  hold_left;
		logic hold_taken;
		hold_left = 0;
		hold_taken = 1'b0;
		out_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	task automatic push_word(input logic c, input logic signed [SW-1:0] l,
			input logic signed [SW-1:0] r, input logic [BSW-1:0] b,
			input logic [CSW-1:0] s, input logic signed [CW-1:0] v);
		while ($urandom_range(99) < tx_idle) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= c;
		in_ch.left_in <= l;
		in_ch.right_in <= r;
		in_ch.band_sel <= b;
		in_ch.coef_sel <= s;
		in_ch.coef_value <= v;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_sample(input logic signed [SW-1:0] l, input logic signed [SW-1:0] r);
		push_word(CMD_SAMPLE, l, r, BSW'($urandom), CSW'($urandom), $urandom);
	endtask

	task automatic send_coef(input logic [BSW-1:0] b, input logic [CSW-1:0] s,
			input logic signed [CW-1:0] v);
		push_word(CMD_WRITE, SW'($urandom), SW'($urandom), b, s, v);
	endtask

	function automatic logic signed [SW-1:0] pick_sample();
		case ($urandom_range(9))
			0: return SW'($urandom);
			1: return $urandom_range(1) ? SMP_MAX : SMP_MIN;
			2: return SW'(int'($urandom_range(2*4096)) - 4096);
			default: return SW'(int'($urandom_range(2*FULL_SCALE)) - FULL_SCALE);
		endcase
	endfunction

	// mostly near-unity sections so the cascade stays out of saturation
	function automatic logic signed [CW-1:0] pick_coef(input logic [CSW-1:0] sel);
		if ($urandom_range(24) == 0)
			return $urandom;
		if (sel == C_B0)
			return Q_ONE + CW'(int'($urandom_range(1 << 26)) - (1 << 25));
		return CW'(int'($urandom_range(1 << 25)) - (1 << 24));
	endfunction

	initial begin
		int r;
		logic [CSW-1:0] sel;
		arst_n = 1'b0;
		hold_req = 1'b0;
		tx_idle = 35;
		rx_idle = 83;
		counted = 0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_SAMPLE;
		in_ch.left_in = '0;
		in_ch.right_in = '0;
		in_ch.band_sel = '0;
		in_ch.coef_sel = '0;
		in_ch.coef_value = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unity cascade: full scale clamps, rounding around zero
		send_sample(SMP_MAX, SMP_MIN);
		send_sample('0, '0);
		send_sample(SW'(-1), SW'(1));
		// maximum gain, unstable pole, and a mild section
		send_coef(BSW'(0), C_B0, COEF_MAX);
		send_sample(SW'(FULL_SCALE), SW'(-FULL_SCALE));
		send_coef(BSW'(BANDS - 1), C_A2, COEF_MIN);
		send_coef(BSW'(5), C_B1, 32'sh0800_0000);
		send_coef(BSW'(5), C_B2, -32'sh0800_0000);
		send_coef(BSW'(5), C_A1, 32'sh0400_0000);
		// writes that must be dropped
		send_coef(BSW'(BANDS), C_B0, '0);
		send_coef(BAND_TOP, C_A1, COEF_MAX);
		send_coef(BSW'(3), SEL_BAD_LO, COEF_MIN);
		send_coef(BSW'(3), SEL_BAD_HI, '0);
		send_sample(SMP_MAX, SMP_MAX);
		send_sample(SMP_MIN, SMP_MIN);
		send_sample(SW'(12345), SW'(-54321));
		send_sample('0, '0);
		send_sample('0, '0);
		send_coef(BSW'(0), C_B0, Q_ONE);
		send_coef(BSW'(BANDS - 1), C_A2, '0);
		send_coef(BSW'(0), C_B0, COEF_MIN);
		send_sample(SW'(1000), SW'(-1000));
		send_coef(BSW'(0), C_B0, Q_ONE);
		send_sample('0, '0);
		send_sample(SW'(-FULL_SCALE), SW'(FULL_SCALE));

		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle = 35;
					rx_idle <= 83;
				end
				1: begin
					tx_idle = 83;
					rx_idle <= 35;
				end
				default: begin
					tx_idle = 0;
					rx_idle <= 0;
					hold_req <= 1'b1;
				end
			endcase
			while (counted < (p + 1) * ITEMS / 3) begin
				r = $urandom_range(99);
				if (r < 72) begin
					send_sample(pick_sample(), pick_sample());
					counted++;
				end else if (r < 95) begin
					sel = CSW'($urandom_range(NCOEF - 1));
					send_coef(BSW'($urandom_range(BANDS - 1)), sel, pick_coef(sel));
					counted++;
				end else if ($urandom_range(1)) begin
					send_coef(BSW'($urandom_range(15, BANDS)), CSW'($urandom), $urandom);
				end else begin
					send_coef(BSW'($urandom_range(BANDS - 1)), CSW'($urandom_range(7, NCOEF)),
						$urandom);
				end
			end
		end

		in_ch.valid <= 1'b0;
		@(posedge clk);
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(posedge clk);
		@(negedge clk);
		if (fails == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/spe_pkg.sv
hw/rtl/spe_in_if.sv
hw/rtl/spe_out_if.sv
hw/rtl/spe_coef_store.sv
hw/rtl/spe_lane.sv
hw/rtl/spe_merge.sv
hw/rtl/stereo_peaking_eq_cascade.sv
tb/sv/spe_eq_checker.sv
tb/sv/stereo_peaking_eq_cascade_tb.sv
